### src/can_frame_tx_rx_queue_top_assert.svh
// Assertion macros for the CAN frame queue.
`ifndef CAN_FRAME_TX_RX_QUEUE_TOP_ASSERT_SVH
`define CAN_FRAME_TX_RX_QUEUE_TOP_ASSERT_SVH

// Check that the antecedent implies the consequent in the same cycle.
`define CFTQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the antecedent implies the consequent in the next cycle.
`define CFTQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/cftq_pkg.sv
// Shared types and constants for the CAN frame queue.
package cftq_pkg;

	localparam int unsigned TX_DEPTH_DEFAULT = 8;
	localparam int unsigned RX_DEPTH_DEFAULT = 8;

	typedef enum logic [1:0] {
		FN_SEND    = 2'd0,
		FN_TX_DONE = 2'd1,
		FN_RX      = 2'd2,
		FN_POP     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic [31:0] id;
		logic [3:0]  len;
		logic [63:0] data;
	} frame_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic rd;
	} ring_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} ring_stat_t;

endpackage

### src/cftq_req_if.sv
// Request channel: one event word per handshake.
interface cftq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] frame_id;
	logic [3:0]  frame_len;
	logic [63:0] frame_data;

	modport source (output valid, func, frame_id, frame_len, frame_data, input ready);
	modport sink (input valid, func, frame_id, frame_len, frame_data, output ready);
endinterface

### src/cftq_rsp_if.sv
// Response channel: one result word per handshake.
interface cftq_rsp_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic        tx_start;
	logic [31:0] tx_id;
	logic [3:0]  tx_len;
	logic [63:0] tx_data;
	logic        rx_dropped;
	logic        rx_available;
	logic [31:0] head_id;
	logic [3:0]  head_len;
	logic [63:0] head_data;

	modport source (output valid, accepted, tx_start, tx_id, tx_len, tx_data, rx_dropped,
		rx_available, head_id, head_len, head_data, input ready);
	modport sink (input valid, accepted, tx_start, tx_id, tx_len, tx_data, rx_dropped,
		rx_available, head_id, head_len, head_data, output ready);
endinterface

### src/cftq_ring.sv
// Frame ring: synchronous memory with free-running write and read pointers.
module cftq_ring import cftq_pkg::*; #(
	parameter int unsigned DEPTH = TX_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ring_cmd_t  cmd,
	input  frame_t     wdata,
	output frame_t     rdata,
	output ring_stat_t stat
);

	localparam int unsigned PW = $clog2(2 * DEPTH);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] PtrDepth = PW'(DEPTH);
	localparam logic [PW-1:0] PtrLast  = PW'(2 * DEPTH - 1);

	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_slot;
	logic [AW-1:0] rd_slot;
	frame_t        mem_q [DEPTH];
	frame_t        rdata_q;

	function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
		logic [PW-1:0] s;
		s = (p >= PtrDepth) ? (p - PtrDepth) : p;
		return s[AW-1:0];
	endfunction

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PtrLast) ? '0 : (p + PW'(1));
	endfunction

	assign wr_slot    = ptr_slot(wr_ptr_q);
	assign rd_slot    = ptr_slot(rd_ptr_q);
	assign stat.empty = (wr_ptr_q == rd_ptr_q);
	assign stat.full  = (wr_slot == rd_slot) && (wr_ptr_q != rd_ptr_q);
	assign rdata      = rdata_q;

	// Advance pointers on push and pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (cmd.push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (cmd.pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
		end
	end

	// Write the tail entry
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[wr_slot] <= wdata;
		end
	end

	// Read the head entry, registered
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem_q[rd_slot];
		end
	end

endmodule

### src/can_frame_tx_rx_queue_top.sv
// CAN frame queue: event sequencer, transmit busy flag and result register.
// Each event passes through accept, ring update with transmit head read, receive
// head read and result load in turn; result load waits while the previous result
// is still held unread. The result is registered at result load; the next event is
// taken while that result waits in the output register.
// Reset clears the pointers, busy flag, sequencer and result valid; the ring
// memories are not cleared and need no clearing pass.
module can_frame_tx_rx_queue_top import cftq_pkg::*; #(
	parameter int unsigned TX_DEPTH = TX_DEPTH_DEFAULT,
	parameter int unsigned RX_DEPTH = RX_DEPTH_DEFAULT
) (
	input logic         clk,
	input logic         arst_n,
	cftq_req_if.sink    req,
	cftq_rsp_if.source  rsp
);

`include "can_frame_tx_rx_queue_top_assert.svh"

	state_t     state_q;
	state_t     state_next;
	func_t      func_q;
	frame_t     frame_q;
	logic       busy_q;
	logic       acc_q;
	logic       start_q;
	logic       direct_q;
	logic       drop_q;
	logic       out_valid_q;
	logic       out_free;
	logic       load_out;
	logic       exec;
	ring_cmd_t  tx_cmd;
	ring_cmd_t  rx_cmd;
	ring_stat_t tx_stat;
	ring_stat_t rx_stat;
	frame_t     tx_head;
	frame_t     rx_head;
	frame_t     tx_frame;
	logic       acc_d;
	logic       start_d;
	logic       direct_d;
	logic       drop_d;
	logic       busy_set;
	logic       busy_clr;

	logic        out_acc_q;
	logic        out_start_q;
	frame_t      out_tx_q;
	logic        out_drop_q;
	logic        out_avail_q;
	frame_t      out_head_q;

	cftq_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tx_cmd),
		.wdata  (frame_q),
		.rdata  (tx_head),
		.stat   (tx_stat)
	);

	cftq_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rx_cmd),
		.wdata  (frame_q),
		.rdata  (rx_head),
		.stat   (rx_stat)
	);

	assign out_free = !out_valid_q || rsp.ready;
	assign exec     = (state_q == ST_EXEC);

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: state_next = ST_READ;
			ST_READ: state_next = ST_LOAD;
			ST_LOAD: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Event decisions and ring commands
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		tx_cmd    = '0;
		rx_cmd    = '0;
		acc_d     = 1'b0;
		start_d   = 1'b0;
		direct_d  = 1'b0;
		drop_d    = 1'b0;
		busy_set  = 1'b0;
		busy_clr  = 1'b0;
		load_out  = (state_q == ST_LOAD) && out_free;
		if (state_q == ST_READ) begin
			rx_cmd.rd = 1'b1;
		end
		if (exec) begin
			case (func_q)
				FN_SEND: begin
					if (!busy_q) begin
						start_d  = 1'b1;
						direct_d = 1'b1;
						busy_set = 1'b1;
						acc_d    = 1'b1;
					end else if (!tx_stat.full) begin
						tx_cmd.push = 1'b1;
						acc_d       = 1'b1;
					end
				end
				FN_TX_DONE: begin
					if (!tx_stat.empty) begin
						tx_cmd.rd  = 1'b1;
						tx_cmd.pop = 1'b1;
						start_d    = 1'b1;
						busy_set   = 1'b1;
					end else begin
						busy_clr = 1'b1;
					end
				end
				FN_RX: begin
					if (!rx_stat.full) begin
						rx_cmd.push = 1'b1;
					end else begin
						drop_d = 1'b1;
					end
				end
				FN_POP: begin
					if (!rx_stat.empty) begin
						rx_cmd.pop = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Sequencer, busy flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (busy_set) begin
				busy_q <= 1'b1;
			end else if (busy_clr) begin
				busy_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the event word
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q       <= func_t'(req.func);
			frame_q.id   <= req.frame_id;
			frame_q.len  <= req.frame_len;
			frame_q.data <= req.frame_data;
		end
	end

	// Hold the event decisions until load
	always_ff @(posedge clk) begin
		if (exec) begin
			acc_q    <= acc_d;
			start_q  <= start_d;
			direct_q <= direct_d;
			drop_q   <= drop_d;
		end
	end

	assign tx_frame = direct_q ? frame_q : tx_head;

	// Load the result register, zeroing fields that carry no frame
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_acc_q   <= acc_q;
			out_start_q <= start_q;
			out_tx_q    <= start_q ? tx_frame : '0;
			out_drop_q  <= drop_q;
			out_avail_q <= !rx_stat.empty;
			out_head_q  <= rx_stat.empty ? '0 : rx_head;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.accepted     = out_acc_q;
	assign rsp.tx_start     = out_start_q;
	assign rsp.tx_id        = out_tx_q.id;
	assign rsp.tx_len       = out_tx_q.len;
	assign rsp.tx_data      = out_tx_q.data;
	assign rsp.rx_dropped   = out_drop_q;
	assign rsp.rx_available = out_avail_q;
	assign rsp.head_id      = out_head_q.id;
	assign rsp.head_len     = out_head_q.len;
	assign rsp.head_data    = out_head_q.data;

	`CFTQ_ASSERT_NEXT(a_accept_to_exec, req.valid && req.ready, state_q == ST_EXEC, "accepted event did not enter update")
	`CFTQ_ASSERT_SAME(a_drop_means_avail, rsp.valid && rsp.rx_dropped, rsp.rx_available, "drop reported with empty receive ring")
	`CFTQ_ASSERT_SAME(a_ring_status, 1'b1, !(tx_stat.empty && tx_stat.full) && !(rx_stat.empty && rx_stat.full), "ring both empty and full")
	`CFTQ_ASSERT_NEXT(a_start_sets_busy, exec && start_d, busy_q, "transmit start left busy clear")

endmodule
